>>> rtl/af3inv_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// af3inv_pkg
// Shared types, constants and index helpers for the 3D affine inverse block.
// ----------------------------------------------------------------------------
package af3inv_pkg;

  localparam int NPARAM          = 12;
  localparam int ADJ_N           = 9;
  localparam int IDX_W           = 4;
  localparam int DATA_W          = 32;
  localparam int THR_W           = 31;
  localparam int FRAC_BITS_DEF   = 16;
  localparam int VALUE_WIDTH_DEF = 32;
  localparam int QDEPTH          = 2;
  localparam logic [THR_W-1:0] THR_RESET = THR_W'(1);
  localparam logic [IDX_W-1:0] LAST_IDX  = IDX_W'(NPARAM - 1);
  localparam logic [IDX_W-1:0] NUM_TRANS = IDX_W'(3);

  typedef logic [1:0] rc_t;

  typedef struct packed {
    logic              store;
    logic [IDX_W-1:0]  idx;
    logic [DATA_W-1:0] value;
    logic              compute;
  } cmd_t;

  typedef enum logic [3:0] {
    B_IDLE,
    B_COF,
    B_FETCH,
    B_LOAD,
    B_MAC,
    B_CHECK,
    B_SING,
    B_AFETCH,
    B_ALOAD,
    B_DIVSET,
    B_DIV,
    B_EMIT
  } back_state_t;

  function automatic rc_t inc3(input rc_t x);
    return (x == 2'd2) ? 2'd0 : x + 2'd1;
  endfunction

  // matrix element m[r][c] sits at parameter 3 + 3c + r
  function automatic logic [IDX_W-1:0] mat_idx(input rc_t r, input rc_t c);
    return IDX_W'(3) + IDX_W'(3) * {2'b00, c} + {2'b00, r};
  endfunction

  function automatic logic [IDX_W-1:0] adj_idx(input rc_t r, input rc_t c);
    return IDX_W'(3) * {2'b00, r} + {2'b00, c};
  endfunction

  // matrix result index to {column, row}
  function automatic logic [3:0] out_cr(input logic [IDX_W-1:0] j);
    logic [3:0] cr;
    case (j)
      4'd3:    cr = {2'd0, 2'd0};
      4'd4:    cr = {2'd0, 2'd1};
      4'd5:    cr = {2'd0, 2'd2};
      4'd6:    cr = {2'd1, 2'd0};
      4'd7:    cr = {2'd1, 2'd1};
      4'd8:    cr = {2'd1, 2'd2};
      4'd9:    cr = {2'd2, 2'd0};
      4'd10:   cr = {2'd2, 2'd1};
      4'd11:   cr = {2'd2, 2'd2};
      default: cr = 4'd0;
    endcase
    return cr;
  endfunction

endpackage
`default_nettype wire

>>> rtl/af3inv_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// af3inv interfaces
// Valid/ready channels for parameter beats, result beats and the threshold.
// ----------------------------------------------------------------------------
interface af3inv_param_if;
  logic                                valid;
  logic                                ready;
  logic [af3inv_pkg::IDX_W-1:0]        param_index;
  logic signed [af3inv_pkg::DATA_W-1:0] param_value;
  logic                                compute_now;
  modport source (output valid, param_index, param_value, compute_now, input ready);
  modport sink (input valid, param_index, param_value, compute_now, output ready);
endinterface

interface af3inv_result_if;
  logic                                valid;
  logic                                ready;
  logic [af3inv_pkg::IDX_W-1:0]        result_index;
  logic signed [af3inv_pkg::DATA_W-1:0] result_value;
  logic                                singular;
  logic                                last_result;
  modport source (output valid, result_index, result_value, singular, last_result,
                  input ready);
  modport sink (input valid, result_index, result_value, singular, last_result,
                output ready);
endinterface

interface af3inv_cfg_if;
  logic                         valid;
  logic                         ready;
  logic [af3inv_pkg::THR_W-1:0] det_threshold;
  modport source (output valid, det_threshold, input ready);
  modport sink (input valid, det_threshold, output ready);
endinterface
`default_nettype wire

>>> rtl/af3inv_ram.sv
`default_nettype none
// ----------------------------------------------------------------------------
// af3inv_ram
// Generic RAM, one write port, two registered read ports.
// ----------------------------------------------------------------------------
module af3inv_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 12,
  localparam int AW   = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr_a,
  input  logic [AW-1:0]    raddr_b,
  output logic [WIDTH-1:0] rdata_a,
  output logic [WIDTH-1:0] rdata_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_a <= mem[raddr_a];
    rdata_b <= mem[raddr_b];
  end

endmodule
`default_nettype wire

>>> rtl/af3inv_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// af3inv_front
// Accept parameter beats, classify them and queue them for the back end.
// ----------------------------------------------------------------------------
module af3inv_front (
  input  logic               clk,
  input  logic               rst,
  af3inv_param_if.sink       param,
  output af3inv_pkg::cmd_t   cmd,
  output logic               cmd_valid,
  input  logic               cmd_pop
);

  localparam int PW = $clog2(af3inv_pkg::QDEPTH);
  localparam int CW = $clog2(af3inv_pkg::QDEPTH + 1);

  af3inv_pkg::cmd_t slots [af3inv_pkg::QDEPTH];
  af3inv_pkg::cmd_t incoming;
  logic [PW-1:0]    wr_ptr;
  logic [PW-1:0]    rd_ptr;
  logic [CW-1:0]    count;
  logic             push;
  logic             pop;

  assign param.ready = (count != CW'(af3inv_pkg::QDEPTH));
  assign push        = param.valid && param.ready;
  assign cmd_valid   = (count != '0);
  assign pop         = cmd_pop && cmd_valid;
  assign cmd         = slots[rd_ptr];

  always_comb begin
    incoming.store   = (param.param_index < af3inv_pkg::IDX_W'(af3inv_pkg::NPARAM));
    incoming.idx     = param.param_index;
    incoming.value   = param.param_value;
    incoming.compute = param.compute_now;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PW'(af3inv_pkg::QDEPTH - 1)) ? '0 : wr_ptr + PW'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PW'(af3inv_pkg::QDEPTH - 1)) ? '0 : rd_ptr + PW'(1);
      end
      case ({push, pop})
        2'b10:   count <= count + CW'(1);
        2'b01:   count <= count - CW'(1);
        default: count <= count;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= incoming;
    end
  end

endmodule
`default_nettype wire

>>> rtl/af3inv_back.sv
`default_nettype none
// ----------------------------------------------------------------------------
// af3inv_back
// Store parameters, form cofactors and determinant, divide and emit results.
// ----------------------------------------------------------------------------
module af3inv_back #(
  parameter int FRAC_BITS   = af3inv_pkg::FRAC_BITS_DEF,
  parameter int VALUE_WIDTH = af3inv_pkg::VALUE_WIDTH_DEF
) (
  input  logic             clk,
  input  logic             rst,
  input  af3inv_pkg::cmd_t cmd,
  input  logic             cmd_valid,
  output logic             cmd_pop,
  af3inv_cfg_if.sink       cfg,
  af3inv_result_if.source  result
);

  localparam int W  = (VALUE_WIDTH < 32) ? VALUE_WIDTH : 32;
  localparam int AW = 2 * W + 1;
  localparam int DW = 3 * W + 3;
  localparam int NW = DW + 2 * FRAC_BITS + 1;
  localparam int IW = $clog2(W);
  localparam int CW = $clog2(NW);
  localparam int XW = af3inv_pkg::IDX_W;

  af3inv_pkg::back_state_t state, state_next;

  logic [af3inv_pkg::THR_W-1:0] thr;
  af3inv_pkg::rc_t cof_r, cof_c, ph, t;
  logic [XW-1:0]   j;
  logic            mode_det;

  logic [XW-1:0]   prm_ra, prm_rb, adj_ra, adj_wa;
  logic            prm_we, adj_we;
  logic [W-1:0]    prm_da, prm_db;
  logic [AW-1:0]   adj_da, adj_wd;

  logic signed [2*W-1:0] mul, prod1, prod2;
  logic signed [DW-1:0]  mac_a, acc;
  logic [W-1:0]          mac_b;
  logic [IW-1:0]         mac_i;
  logic                  mac_last;
  logic [DW-1:0]         acc_abs;
  logic                  is_sing;

  logic [NW-1:0]         dmag, dvd, rem, quo, rem_sh, rem_next, num_abs, lim;
  logic signed [NW-1:0]  num;
  logic                  det_neg, q_neg, ge;
  logic [CW-1:0]         div_cnt;
  logic signed [AW-1:0]  adj_hold;
  logic [W-1:0]          sat_v;
  logic [3:0]            cr;

  logic                  emit, emit_ok, res_valid;

  af3inv_ram #(.WIDTH(W), .DEPTH(af3inv_pkg::NPARAM)) u_prm (
    .clk(clk), .we(prm_we), .waddr(cmd.idx), .wdata(cmd.value[W-1:0]),
    .raddr_a(prm_ra), .raddr_b(prm_rb), .rdata_a(prm_da), .rdata_b(prm_db)
  );

  af3inv_ram #(.WIDTH(AW), .DEPTH(af3inv_pkg::ADJ_N)) u_adj (
    .clk(clk), .we(adj_we), .waddr(adj_wa), .wdata(adj_wd),
    .raddr_a(adj_ra), .raddr_b('0), .rdata_a(adj_da), .rdata_b()
  );

  assign cfg.ready    = 1'b1;
  assign result.valid = res_valid;
  assign emit_ok      = !res_valid || result.ready;

  assign mul      = $signed(prm_da) * $signed(prm_db);
  assign adj_wd   = AW'(prod1) - AW'(prod2);
  assign mac_last = (mac_i == IW'(W - 1));
  assign acc_abs  = acc[DW-1] ? DW'(-acc) : DW'(acc);
  assign is_sing  = ((NW'(thr) << (2 * FRAC_BITS)) >= NW'(acc_abs));
  assign cr       = af3inv_pkg::out_cr(j);

  always_comb begin
    if (j < af3inv_pkg::NUM_TRANS) begin
      num = (-NW'(acc)) << FRAC_BITS;
    end else begin
      num = NW'(adj_hold) << (2 * FRAC_BITS);
    end
    num_abs = num[NW-1] ? NW'(-num) : NW'(num);
  end

  assign rem_sh   = {rem[NW-2:0], dvd[NW-1]};
  assign ge       = (rem_sh >= dmag);
  assign rem_next = ge ? rem_sh - dmag : rem_sh;
  assign lim      = NW'(1) << (W - 1);

  always_comb begin
    if (q_neg) begin
      sat_v = (quo > lim) ? W'(0) - lim[W-1:0] : W'(0) - quo[W-1:0];
    end else begin
      sat_v = (quo > lim - NW'(1)) ? W'(lim - NW'(1)) : quo[W-1:0];
    end
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      af3inv_pkg::B_IDLE: begin
        if (cmd_valid && cmd.compute) state_next = af3inv_pkg::B_COF;
      end
      af3inv_pkg::B_COF: begin
        if (ph == 2'd3 && cof_r == 2'd2 && cof_c == 2'd2) state_next = af3inv_pkg::B_FETCH;
      end
      af3inv_pkg::B_FETCH: state_next = af3inv_pkg::B_LOAD;
      af3inv_pkg::B_LOAD:  state_next = af3inv_pkg::B_MAC;
      af3inv_pkg::B_MAC: begin
        if (mac_last) begin
          if (t != 2'd2)     state_next = af3inv_pkg::B_FETCH;
          else if (mode_det) state_next = af3inv_pkg::B_CHECK;
          else               state_next = af3inv_pkg::B_DIVSET;
        end
      end
      af3inv_pkg::B_CHECK: begin
        state_next = is_sing ? af3inv_pkg::B_SING : af3inv_pkg::B_FETCH;
      end
      af3inv_pkg::B_SING: begin
        if (emit_ok) state_next = af3inv_pkg::B_IDLE;
      end
      af3inv_pkg::B_AFETCH: state_next = af3inv_pkg::B_ALOAD;
      af3inv_pkg::B_ALOAD:  state_next = af3inv_pkg::B_DIVSET;
      af3inv_pkg::B_DIVSET: state_next = af3inv_pkg::B_DIV;
      af3inv_pkg::B_DIV: begin
        if (div_cnt == CW'(NW - 1)) state_next = af3inv_pkg::B_EMIT;
      end
      af3inv_pkg::B_EMIT: begin
        if (emit_ok) begin
          if (j == af3inv_pkg::LAST_IDX)                  state_next = af3inv_pkg::B_IDLE;
          else if (j + XW'(1) < af3inv_pkg::NUM_TRANS)    state_next = af3inv_pkg::B_FETCH;
          else                                            state_next = af3inv_pkg::B_AFETCH;
        end
      end
      default: state_next = af3inv_pkg::B_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    cmd_pop = 1'b0;
    prm_we  = 1'b0;
    adj_we  = 1'b0;
    prm_ra  = '0;
    prm_rb  = '0;
    adj_ra  = '0;
    adj_wa  = af3inv_pkg::adj_idx(cof_r, cof_c);
    emit    = 1'b0;
    case (state)
      af3inv_pkg::B_IDLE: begin
        cmd_pop = cmd_valid;
        prm_we  = cmd_valid && cmd.store;
      end
      af3inv_pkg::B_COF: begin
        if (ph == 2'd0) begin
          prm_ra = af3inv_pkg::mat_idx(af3inv_pkg::inc3(cof_c), af3inv_pkg::inc3(cof_r));
          prm_rb = af3inv_pkg::mat_idx(af3inv_pkg::inc3(af3inv_pkg::inc3(cof_c)),
                                       af3inv_pkg::inc3(af3inv_pkg::inc3(cof_r)));
        end else begin
          prm_ra = af3inv_pkg::mat_idx(af3inv_pkg::inc3(cof_c),
                                       af3inv_pkg::inc3(af3inv_pkg::inc3(cof_r)));
          prm_rb = af3inv_pkg::mat_idx(af3inv_pkg::inc3(af3inv_pkg::inc3(cof_c)),
                                       af3inv_pkg::inc3(cof_r));
        end
        adj_we = (ph == 2'd3);
      end
      af3inv_pkg::B_FETCH: begin
        if (mode_det) begin
          adj_ra = af3inv_pkg::adj_idx(t, 2'd0);
          prm_ra = af3inv_pkg::mat_idx(2'd0, t);
        end else begin
          adj_ra = af3inv_pkg::adj_idx(j[1:0], t);
          prm_ra = {2'b00, t};
        end
      end
      af3inv_pkg::B_AFETCH: adj_ra = af3inv_pkg::adj_idx(cr[1:0], cr[3:2]);
      af3inv_pkg::B_SING:   emit   = emit_ok;
      af3inv_pkg::B_EMIT:   emit   = emit_ok;
      default: ;
    endcase
  end

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= af3inv_pkg::B_IDLE;
      thr       <= af3inv_pkg::THR_RESET;
      res_valid <= 1'b0;
      cof_r     <= '0;
      cof_c     <= '0;
      ph        <= '0;
      t         <= '0;
      j         <= '0;
      mode_det  <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg.valid) thr <= cfg.det_threshold;
      if (emit) res_valid <= 1'b1;
      else if (result.ready) res_valid <= 1'b0;
      case (state)
        af3inv_pkg::B_IDLE: begin
          cof_r <= '0;
          cof_c <= '0;
          ph    <= '0;
        end
        af3inv_pkg::B_COF: begin
          ph <= ph + 2'd1;
          if (ph == 2'd3) begin
            if (cof_c == 2'd2) begin
              cof_c <= '0;
              cof_r <= cof_r + 2'd1;
            end else begin
              cof_c <= cof_c + 2'd1;
            end
            mode_det <= 1'b1;
            t        <= '0;
          end
        end
        af3inv_pkg::B_MAC: begin
          if (mac_last && t != 2'd2) t <= t + 2'd1;
        end
        af3inv_pkg::B_CHECK: begin
          j        <= '0;
          t        <= '0;
          mode_det <= 1'b0;
        end
        af3inv_pkg::B_EMIT: begin
          if (emit_ok) begin
            j <= j + XW'(1);
            t <= '0;
          end
        end
        default: ;
      endcase
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    case (state)
      af3inv_pkg::B_COF: begin
        if (ph == 2'd1) prod1 <= mul;
        if (ph == 2'd2) prod2 <= mul;
      end
      af3inv_pkg::B_FETCH: begin
        if (t == 2'd0) acc <= '0;
      end
      af3inv_pkg::B_LOAD: begin
        mac_a <= DW'($signed(adj_da));
        mac_b <= prm_da;
        mac_i <= '0;
      end
      af3inv_pkg::B_MAC: begin
        if (mac_b[0]) acc <= mac_last ? acc - mac_a : acc + mac_a;
        mac_a <= mac_a << 1;
        mac_b <= mac_b >> 1;
        mac_i <= mac_i + IW'(1);
      end
      af3inv_pkg::B_CHECK: begin
        dmag    <= NW'(acc_abs);
        det_neg <= acc[DW-1];
      end
      af3inv_pkg::B_ALOAD: adj_hold <= adj_da;
      af3inv_pkg::B_DIVSET: begin
        dvd     <= num_abs;
        q_neg   <= num[NW-1] ^ det_neg;
        rem     <= '0;
        quo     <= '0;
        div_cnt <= '0;
      end
      af3inv_pkg::B_DIV: begin
        rem     <= rem_next;
        quo     <= {quo[NW-2:0], ge};
        dvd     <= dvd << 1;
        div_cnt <= div_cnt + CW'(1);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      if (state == af3inv_pkg::B_SING) begin
        result.result_index <= '0;
        result.result_value <= '0;
        result.singular     <= 1'b1;
        result.last_result  <= 1'b1;
      end else begin
        result.result_index <= j;
        result.result_value <= af3inv_pkg::DATA_W'($signed(sat_v));
        result.singular     <= 1'b0;
        result.last_result  <= (j == af3inv_pkg::LAST_IDX);
      end
    end
  end

`ifndef NO_ASSERTIONS
  a_last_beat: assert property (@(posedge clk) disable iff (rst)
    result.valid && result.last_result |->
      (result.singular || result.result_index == af3inv_pkg::LAST_IDX))
    else $error("last beat neither singular nor final index");

  a_start: assert property (@(posedge clk) disable iff (rst)
    (state == af3inv_pkg::B_COF && $past(state) == af3inv_pkg::B_IDLE) |->
      $past(cmd_valid && cmd.compute))
    else $error("inversion started without a compute beat");

  a_rem: assert property (@(posedge clk) disable iff (rst)
    state == af3inv_pkg::B_DIV |-> rem < dmag)
    else $error("divider remainder out of range");

  a_div0: assert property (@(posedge clk) disable iff (rst)
    state == af3inv_pkg::B_DIVSET |-> dmag != '0)
    else $error("division by zero determinant");
`endif

endmodule
`default_nettype wire

>>> rtl/affine_3d_inverse_top.sv
`default_nettype none
// ----------------------------------------------------------------------------
// affine_3d_inverse_top
// Inverts a 3D affine transform loaded as twelve signed fixed-point beats.
// ----------------------------------------------------------------------------
// A parameter beat is accepted and queued; a short queue lets loading run ahead
// of the inversion. A compute beat first forms the cofactors, then the determinant
// on a bit-serial multiply-accumulate over W = min(VALUE_WIDTH, 32) bits, then
// per result one divide (one quotient bit a cycle) after its set-up; each of the
// three translation results first takes another multiply-accumulate.
// A singular inversion ends after the determinant check. The divider and the
// serial multiplier set the length of an inversion.
module affine_3d_inverse_top #(
  parameter int FRAC_BITS   = af3inv_pkg::FRAC_BITS_DEF,
  parameter int VALUE_WIDTH = af3inv_pkg::VALUE_WIDTH_DEF
) (
  input  logic            clk,
  input  logic            rst,
  af3inv_param_if.sink    param,
  af3inv_result_if.source result,
  af3inv_cfg_if.sink      cfg
);

  af3inv_pkg::cmd_t cmd;
  logic             cmd_valid;
  logic             cmd_pop;

  af3inv_front u_front (
    .clk(clk), .rst(rst), .param(param),
    .cmd(cmd), .cmd_valid(cmd_valid), .cmd_pop(cmd_pop)
  );

  af3inv_back #(.FRAC_BITS(FRAC_BITS), .VALUE_WIDTH(VALUE_WIDTH)) u_back (
    .clk(clk), .rst(rst), .cmd(cmd), .cmd_valid(cmd_valid), .cmd_pop(cmd_pop),
    .cfg(cfg), .result(result)
  );

endmodule
`default_nettype wire

>>> dv/af3inv_checker.sv
// ----------------------------------------------------------------------------
// af3inv_checker
// Watches the parameter, threshold and result channels of the affine inverse
// block, keeps its own copy of the stored transform and threshold, works out
// the inverse for every compute beat with exact wide arithmetic and compares
// each result beat, field by field, with the oldest expected beat.
// ----------------------------------------------------------------------------
module af3inv_checker (
  input  logic     clk,
  input  logic     rst,
  af3inv_param_if  param_bus,
  af3inv_result_if result_bus,
  af3inv_cfg_if    cfg_bus,
  output int       errors,
  output int       pending
);
  import af3inv_pkg::*;

  localparam int F         = FRAC_BITS_DEF;
  localparam int MAX_PRINT = 10;

  typedef logic signed [127:0] wide_t;

  typedef struct {
    logic [IDX_W-1:0]         idx;
    logic signed [DATA_W-1:0] value;
    logic                     sing;
    logic                     last;
  } inv_beat_t;

  logic signed [DATA_W-1:0] xform[NPARAM];
  logic [THR_W-1:0]         thr;
  inv_beat_t                inverse_q[$];

  assign pending = inverse_q.size();

  function automatic logic signed [DATA_W-1:0] sat_div(wide_t num, wide_t den);
    wide_t q;
    q = num / den;
    if (q > wide_t'(32'sh7fffffff)) return 32'sh7fffffff;
    if (q < -wide_t'(64'sh80000000)) return 32'sh80000000;
    return q[DATA_W-1:0];
  endfunction

  function automatic void invert_xform();
    wide_t     m[3][3];
    wide_t     b[3];
    wide_t     adj[3][3];
    wide_t     det, mag, s;
    inv_beat_t e;
    int        k;
    for (int r = 0; r < 3; r++) begin
      b[r] = wide_t'(xform[r]);
      for (int c = 0; c < 3; c++) m[r][c] = wide_t'(xform[3 + 3*c + r]);
    end
    for (int r = 0; r < 3; r++)
      for (int c = 0; c < 3; c++)
        adj[r][c] = m[(c+1)%3][(r+1)%3] * m[(c+2)%3][(r+2)%3]
                  - m[(c+1)%3][(r+2)%3] * m[(c+2)%3][(r+1)%3];
    det = 0;
    for (int i = 0; i < 3; i++) det += m[0][i] * adj[i][0];
    mag = (det < 0) ? -det : det;
    if (mag <= (wide_t'({1'b0, thr}) <<< (2*F))) begin
      e = '{idx: '0, value: '0, sing: 1'b1, last: 1'b1};
      inverse_q.push_back(e);
      return;
    end
    for (int r = 0; r < 3; r++) begin
      s = 0;
      for (int c = 0; c < 3; c++) s += adj[r][c] * b[c];
      e = '{idx: IDX_W'(r), value: sat_div((-s) <<< F, det), sing: 1'b0, last: 1'b0};
      inverse_q.push_back(e);
    end
    for (int c = 0; c < 3; c++)
      for (int r = 0; r < 3; r++) begin
        k = 3 + 3*c + r;
        e.idx   = IDX_W'(k);
        e.value = sat_div(adj[r][c] <<< (2*F), det);
        e.sing  = 1'b0;
        e.last  = (IDX_W'(k) == LAST_IDX);
        inverse_q.push_back(e);
      end
  endfunction

  always @(posedge clk) begin
    inv_beat_t e;
    if (rst) begin
      thr = THR_RESET;
      foreach (xform[i]) xform[i] = '0;
      inverse_q.delete();
      errors = 0;
    end else begin
      if (cfg_bus.valid && cfg_bus.ready) thr = cfg_bus.det_threshold;
      if (result_bus.valid && result_bus.ready) begin
        if (inverse_q.size() == 0) begin
          errors++;
          if (errors <= MAX_PRINT)
            $display("unexpected result beat: idx %0d value %h sing %b last %b",
                     result_bus.result_index, result_bus.result_value,
                     result_bus.singular, result_bus.last_result);
        end else begin
          e = inverse_q.pop_front();
          if (result_bus.result_index !== e.idx || result_bus.result_value !== e.value ||
              result_bus.singular !== e.sing || result_bus.last_result !== e.last) begin
            errors++;
            if (errors <= MAX_PRINT)
              $display("result mismatch: exp idx %0d value %h sing %b last %b, got %0d %h %b %b",
                       e.idx, e.value, e.sing, e.last, result_bus.result_index,
                       result_bus.result_value, result_bus.singular,
                       result_bus.last_result);
          end
        end
      end
      if (param_bus.valid && param_bus.ready) begin
        if (param_bus.param_index < IDX_W'(NPARAM))
          xform[param_bus.param_index] = param_bus.param_value;
        if (param_bus.compute_now) invert_xform();
      end
    end
  end

endmodule

>>> dv/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Loads transforms into the affine inverse block over several threshold
// settings: a directed opening, then random well-formed loads, partial
// updates and noise, with random gaps on both sides and one long receiver
// hold. The checker predicts and compares; this module gives the verdict.
// ----------------------------------------------------------------------------
module tb_top;
  import af3inv_pkg::*;

  localparam int DRAIN_CYCLES = 300;
  localparam int HOLD_CYCLES  = 4000;
  localparam int IDLE_LIMIT   = 20000;
  localparam int PHASE_ITEMS  = 92;

  typedef enum int {K_SMALL, K_TINY, K_FULL, K_EXTREME, K_SINGULAR} val_kind_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  int   errors, pending;
  int   items_sent = 0;
  int   results_seen = 0;
  int   idle_cycles = 0;

  af3inv_param_if  param_bus();
  af3inv_result_if result_bus();
  af3inv_cfg_if    cfg_bus();

  affine_3d_inverse_top i_dut (
    .clk    (clk),
    .rst    (rst),
    .param  (param_bus),
    .result (result_bus),
    .cfg    (cfg_bus)
  );

  af3inv_checker i_checker (
    .clk        (clk),
    .rst        (rst),
    .param_bus  (param_bus),
    .result_bus (result_bus),
    .cfg_bus    (cfg_bus),
    .errors     (errors),
    .pending    (pending)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (result_bus.valid && result_bus.ready) results_seen++;
    if ((param_bus.valid && param_bus.ready) || (result_bus.valid && result_bus.ready) ||
        (cfg_bus.valid && cfg_bus.ready) || rst)
      idle_cycles = 0;
    else
      idle_cycles++;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  // result side: random stalls, one steady stretch, one long hold
  initial begin
    bit held = 1'b0;
    result_bus.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (!held && results_seen >= 40) begin
        held = 1'b1;
        result_bus.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
      end
      if (results_seen >= 100 && results_seen < 250)
        result_bus.ready <= 1'b1;
      else
        result_bus.ready <= ($urandom_range(99) >= 10);
    end
  end

  function automatic logic [DATA_W-1:0] gen_value(val_kind_t kind);
    logic [DATA_W-1:0] picks[5];
    picks = '{32'h7fffffff, 32'h80000000, 32'h0, 32'h1, 32'hffffffff};
    case (kind)
      K_SMALL:   return $urandom_range(0, 8 << 16) - (4 << 16);
      K_TINY:    return $urandom_range(0, 512) - 256;
      K_FULL:    return $urandom;
      K_EXTREME: return picks[$urandom_range(4)];
      default:   return $urandom_range(0, 2) << 16;
    endcase
  endfunction

  task automatic send_param(logic [IDX_W-1:0] idx, logic [DATA_W-1:0] value, logic cmp);
    while ($urandom_range(99) < 10 && !(items_sent >= 150 && items_sent < 260)) begin
      param_bus.valid <= 1'b0;
      @(negedge clk);
    end
    param_bus.valid       <= 1'b1;
    param_bus.param_index <= idx;
    param_bus.param_value <= value;
    param_bus.compute_now <= cmp;
    do @(posedge clk); while (!param_bus.ready);
    items_sent++;
    @(negedge clk);
  endtask

  task automatic write_threshold(logic [THR_W-1:0] value);
    param_bus.valid <= 1'b0;
    wait (pending == 0);
    repeat (DRAIN_CYCLES) @(negedge clk);
    cfg_bus.valid         <= 1'b1;
    cfg_bus.det_threshold <= value;
    do @(posedge clk); while (!cfg_bus.ready);
    @(negedge clk);
    cfg_bus.valid <= 1'b0;
  endtask

  task automatic load_xform(val_kind_t kind, bit shuffle);
    logic [IDX_W-1:0] order[NPARAM];
    logic [IDX_W-1:0] t;
    int j;
    foreach (order[i]) order[i] = IDX_W'(i);
    if (shuffle)
      for (int i = NPARAM - 1; i > 0; i--) begin
        j = $urandom_range(i);
        t = order[i];
        order[i] = order[j];
        order[j] = t;
      end
    for (int i = 0; i < NPARAM; i++)
      send_param(order[i],
                 (order[i] < NUM_TRANS) ? gen_value(K_SMALL) :
                 ($urandom_range(9) == 0 ? gen_value(K_EXTREME) : gen_value(kind)),
                 i == NPARAM - 1);
  endtask

  task automatic random_phase(int count);
    int stop, r, n;
    stop = items_sent + count;
    while (items_sent < stop) begin
      r = $urandom_range(99);
      if (r < 70) begin
        load_xform(val_kind_t'($urandom_range(4)), 1'($urandom_range(1)));
      end else if (r < 85) begin
        n = $urandom_range(1, 4);
        for (int i = 0; i < n; i++)
          send_param(IDX_W'($urandom_range(NPARAM - 1)), gen_value(K_SMALL), i == n - 1);
      end else begin
        send_param(IDX_W'($urandom_range(15)), $urandom, 1'($urandom_range(1)));
      end
    end
  endtask

  initial begin
    param_bus.valid       = 1'b0;
    param_bus.param_index = '0;
    param_bus.param_value = '0;
    param_bus.compute_now = 1'b0;
    cfg_bus.valid         = 1'b0;
    cfg_bus.det_threshold = '0;
    repeat (9) @(negedge clk);
    rst = 1'b0;

    // identity with an offset, then edits that hit the special cases
    for (int i = 0; i < NPARAM; i++)
      send_param(IDX_W'(i), (i == 3 || i == 7 || i == 11) ? 32'h00010000 :
                 (i < 3) ? 32'(i + 1) << 16 : 32'h0, i == NPARAM - 1);
    send_param(IDX_W'(3), 32'h0, 1'b1);
    send_param(IDX_W'(3), 32'h00000100, 1'b0);
    send_param(IDX_W'(7), 32'h00000100, 1'b0);
    send_param(IDX_W'(11), 32'h00000100, 1'b1);
    send_param(IDX_W'(0), 32'h80000000, 1'b0);
    send_param(IDX_W'(1), 32'h7fffffff, 1'b1);
    send_param(IDX_W'(3), 32'h7fffffff, 1'b0);
    send_param(IDX_W'(7), 32'h80000000, 1'b0);
    send_param(IDX_W'(11), 32'h7fffffff, 1'b1);
    send_param(IDX_W'(13), 32'hffffffff, 1'b1);
    send_param(IDX_W'(15), 32'h12345678, 1'b0);

    random_phase(PHASE_ITEMS);
    write_threshold('0);
    random_phase(PHASE_ITEMS);
    write_threshold({THR_W{1'b1}});
    random_phase(PHASE_ITEMS / 2);
    write_threshold(THR_W'($urandom_range(1 << 20)));
    random_phase(PHASE_ITEMS);
    write_threshold(THR_W'(1 << 16));
    random_phase(PHASE_ITEMS);
    write_threshold(THR_RESET);
    random_phase(PHASE_ITEMS / 2);

    param_bus.valid <= 1'b0;
    wait (pending == 0);
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (errors == 0 && pending == 0)
      $display("TEST PASSED");
    else
      $display("TEST FAILED");
    $finish;
  end

endmodule

>>> affine_3d_inverse_top.f
rtl/af3inv_pkg.sv
rtl/af3inv_if.sv
rtl/af3inv_ram.sv
rtl/af3inv_front.sv
rtl/af3inv_back.sv
rtl/affine_3d_inverse_top.sv
dv/af3inv_checker.sv
dv/tb_top.sv
